// ===== sv/pmc_pkg.sv =====
`default_nettype none

package pmc_pkg;

    localparam int DP_W    = 112;
    localparam int MP_W    = 30;
    localparam int DVS_W   = 24;
    localparam int WET_W   = 52;
    localparam int CNT_W   = 7;
    localparam int MASS_W  = 40;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_DENSITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KAPPA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROWTH  = 2'd2;

    localparam logic [14:0] DENSITY_RST = 15'd1650;
    localparam logic [11:0] KAPPA_RST   = 12'd307;

    localparam logic [MP_W-1:0]  MASS_SCALE  = 30'd878452976;
    localparam logic [DP_W-1:0]  NUM_SCALE   = 112'd1000000;
    localparam logic [23:0]      MIN_VOLUME  = 24'd1000;
    localparam logic [16:0]      MAX_MID_SUM = 17'd20480;
    localparam logic [WET_W-1:0] CUT_PM1     = 52'd1 << 33;
    localparam logic [WET_W-1:0] CUT_PM2P5   = 52'd125 << 30;
    localparam logic [WET_W-1:0] CUT_PM10    = 52'd1000 << 33;
    localparam logic [9:0]       RH_MIN      = 10'd100;
    localparam logic [9:0]       RH_CAP      = 10'd980;
    localparam logic [9:0]       RH_FULL     = 10'd1000;

    typedef struct packed {
        logic [23:0] bin_count;
        logic [15:0] edge_low;
        logic [15:0] edge_high;
        logic [23:0] volume_ul;
        logic [9:0]  rel_humidity;
        logic        last_bin;
    } t_in;

    typedef struct packed {
        logic [31:0] num_per_litre;
        logic [39:0] pm1_mass;
        logic [39:0] pm2p5_mass;
        logic [39:0] pm10_mass;
        logic        frame_done;
        logic        volume_too_small;
    } t_out;

    typedef enum logic [2:0] {
        DP_IDLE,
        DP_MUL_LD,
        DP_MUL,
        DP_DIV_LD,
        DP_DIV
    } t_dp_op;

    typedef struct packed {
        t_dp_op          op;
        logic [DP_W-1:0] opa;
        logic [MP_W-1:0] opb;
    } t_dp_cmd;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_NUM_MUL,
        ST_NUM_DL,
        ST_NUM_DIV,
        ST_NUM_WB,
        ST_SQ,
        ST_CUBE_LD,
        ST_CUBE,
        ST_CUBE_WB,
        ST_G_MUL,
        ST_G_DL,
        ST_G_DIV,
        ST_G_WB,
        ST_CUT,
        ST_M_CNT,
        ST_M_DEN_LD,
        ST_M_DEN,
        ST_M_K_LD,
        ST_M_K,
        ST_M_DL,
        ST_M_DIV,
        ST_ACC,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/particle_mass_concentration.sv =====
`default_nettype none

// Particle mass concentration from optical counter size bins.
// Input channel: i_valid / o_stall with i_data, one size bin per beat; a frame
// is the run of bins up to and including the one with last_bin set. Volume and
// humidity are taken from the first bin of each frame.
// Output channel: o_valid / i_stall with o_data, exactly one beat per input
// beat, in order. Mass sums are shown on the beat with frame_done set.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 density, 1 kappa, 2 growth enable). The user must write only while the
// block is idle; the block itself does not enforce it. One bin is worked
// through a single bit-serial multiply/divide unit, one bit per cycle. A
// small-volume frame skips the arithmetic, an oversized bin stops after the
// number concentration, a dry bin skips the growth step and a bin landing
// beyond PM10 adds no mass. The next bin can be taken in the cycle after the
// result reaches the output register; no new bin is taken before then.
// Reset clears the frame state, the sums, the output valid flag and restores
// the register defaults. A stalled output holds its beat; the block takes
// the next bin meanwhile and waits only when it has a second result ready.
module particle_mass_concentration (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire pmc_pkg::t_in                     i_data,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output pmc_pkg::t_out                         o_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [pmc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pmc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    pmc_pkg::t_state r_state, n_state;
    logic [pmc_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [14:0]                r_density;
    logic [11:0]                r_kappa;
    logic                       r_growth;
    logic                       r_in_frame, n_in_frame;
    logic [23:0]                r_vol, n_vol;
    logic [9:0]                 r_hum, n_hum;
    logic [23:0]                r_count, n_count;
    logic [16:0]                r_s, n_s;
    logic                       r_last, n_last;
    logic [31:0]                r_num, n_num;
    logic [pmc_pkg::WET_W-1:0]  r_wet, n_wet;
    logic [39:0]                r_pm1, n_pm1;
    logic [39:0]                r_pm25, n_pm25;
    logic [39:0]                r_pm10, n_pm10;
    logic                       r_out_valid, n_out_valid;
    pmc_pkg::t_out              r_out, n_out;

    pmc_pkg::t_dp_cmd           cmd;
    logic [pmc_pkg::DP_W-1:0]   acc;

    logic                       vol_small;
    logic                       grow;
    logic [9:0]                 rh;
    logic [19:0]                gden;
    logic [22:0]                gnum;
    logic                       accept;
    logic                       out_free;
    logic                       cnt_end;
    logic [39:0]                mass;

    function automatic logic [39:0] sat_add(input logic [39:0] a, input logic [39:0] b);
        logic [40:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[40] ? '1 : sum[39:0];
    endfunction

    pmc_serial u_serial (
        .i_clk (i_clk),
        .i_cmd (cmd),
        .o_acc (acc)
    );

    always_comb begin
        vol_small = r_vol < pmc_pkg::MIN_VOLUME;
        rh        = (r_hum > pmc_pkg::RH_CAP) ? pmc_pkg::RH_CAP : r_hum;
        grow      = r_growth && (r_hum >= pmc_pkg::RH_MIN);
        gden      = {10'(pmc_pkg::RH_FULL - rh), 10'b0};
        gnum      = 23'(gden) + 23'(r_kappa) * 23'(rh);
        accept    = i_valid && !o_stall;
        out_free  = !r_out_valid || !i_stall;
        cnt_end   = r_cnt == '0;
        mass      = (acc[54:40] != '0) ? '1 : acc[39:0];
    end

    assign o_stall = r_state != pmc_pkg::ST_IDLE;

    always_comb begin
        n_state     = r_state;
        n_cnt       = cnt_end ? r_cnt : r_cnt - 1'b1;
        n_in_frame  = r_in_frame;
        n_vol       = r_vol;
        n_hum       = r_hum;
        n_count     = r_count;
        n_s         = r_s;
        n_last      = r_last;
        n_num       = r_num;
        n_wet       = r_wet;
        n_pm1       = r_pm1;
        n_pm25      = r_pm25;
        n_pm10      = r_pm10;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        cmd.op      = pmc_pkg::DP_IDLE;
        cmd.opa     = '0;
        cmd.opb     = '0;

        case (r_state)
            pmc_pkg::ST_IDLE: begin
                if (accept) begin
                    n_count = i_data.bin_count;
                    n_s     = 17'(i_data.edge_low) + 17'(i_data.edge_high);
                    n_last  = i_data.last_bin;
                    if (!r_in_frame) begin
                        n_vol      = i_data.volume_ul;
                        n_hum      = i_data.rel_humidity;
                        n_in_frame = 1'b1;
                    end
                    n_state = pmc_pkg::ST_START;
                end
            end
            pmc_pkg::ST_START: begin
                n_num = '0;
                if (vol_small) begin
                    n_state = pmc_pkg::ST_DONE;
                end else begin
                    cmd.op  = pmc_pkg::DP_MUL_LD;
                    cmd.opa = pmc_pkg::NUM_SCALE;
                    cmd.opb = pmc_pkg::MP_W'(r_count);
                    n_cnt   = pmc_pkg::CNT_W'(23);
                    n_state = pmc_pkg::ST_NUM_MUL;
                end
            end
            pmc_pkg::ST_NUM_MUL: begin
                cmd.op = pmc_pkg::DP_MUL;
                if (cnt_end) n_state = pmc_pkg::ST_NUM_DL;
            end
            pmc_pkg::ST_NUM_DL: begin
                cmd.op  = pmc_pkg::DP_DIV_LD;
                cmd.opa = {acc[43:0], 68'b0};
                cmd.opb = pmc_pkg::MP_W'(r_vol);
                n_cnt   = pmc_pkg::CNT_W'(43);
                n_state = pmc_pkg::ST_NUM_DIV;
            end
            pmc_pkg::ST_NUM_DIV: begin
                cmd.op = pmc_pkg::DP_DIV;
                if (cnt_end) n_state = pmc_pkg::ST_NUM_WB;
            end
            pmc_pkg::ST_NUM_WB: begin
                n_num = (acc[43:32] != '0) ? '1 : acc[31:0];
                if (r_s > pmc_pkg::MAX_MID_SUM) begin
                    n_state = pmc_pkg::ST_DONE;
                end else begin
                    cmd.op  = pmc_pkg::DP_MUL_LD;
                    cmd.opa = pmc_pkg::DP_W'(r_s);
                    cmd.opb = pmc_pkg::MP_W'(r_s);
                    n_cnt   = pmc_pkg::CNT_W'(16);
                    n_state = pmc_pkg::ST_SQ;
                end
            end
            pmc_pkg::ST_SQ: begin
                cmd.op = pmc_pkg::DP_MUL;
                if (cnt_end) n_state = pmc_pkg::ST_CUBE_LD;
            end
            pmc_pkg::ST_CUBE_LD: begin
                cmd.op  = pmc_pkg::DP_MUL_LD;
                cmd.opa = acc;
                cmd.opb = pmc_pkg::MP_W'(r_s);
                n_cnt   = pmc_pkg::CNT_W'(16);
                n_state = pmc_pkg::ST_CUBE;
            end
            pmc_pkg::ST_CUBE: begin
                cmd.op = pmc_pkg::DP_MUL;
                if (cnt_end) n_state = pmc_pkg::ST_CUBE_WB;
            end
            pmc_pkg::ST_CUBE_WB: begin
                n_wet = acc[pmc_pkg::WET_W-1:0];
                if (grow) begin
                    cmd.op  = pmc_pkg::DP_MUL_LD;
                    cmd.opa = acc;
                    cmd.opb = pmc_pkg::MP_W'(gnum);
                    n_cnt   = pmc_pkg::CNT_W'(22);
                    n_state = pmc_pkg::ST_G_MUL;
                end else begin
                    n_state = pmc_pkg::ST_CUT;
                end
            end
            pmc_pkg::ST_G_MUL: begin
                cmd.op = pmc_pkg::DP_MUL;
                if (cnt_end) n_state = pmc_pkg::ST_G_DL;
            end
            pmc_pkg::ST_G_DL: begin
                cmd.op  = pmc_pkg::DP_DIV_LD;
                cmd.opa = {acc[65:0], 46'b0};
                cmd.opb = pmc_pkg::MP_W'(gden);
                n_cnt   = pmc_pkg::CNT_W'(65);
                n_state = pmc_pkg::ST_G_DIV;
            end
            pmc_pkg::ST_G_DIV: begin
                cmd.op = pmc_pkg::DP_DIV;
                if (cnt_end) n_state = pmc_pkg::ST_G_WB;
            end
            pmc_pkg::ST_G_WB: begin
                n_wet   = acc[pmc_pkg::WET_W-1:0];
                n_state = pmc_pkg::ST_CUT;
            end
            pmc_pkg::ST_CUT: begin
                if (r_wet > pmc_pkg::CUT_PM10) begin
                    n_state = pmc_pkg::ST_DONE;
                end else begin
                    cmd.op  = pmc_pkg::DP_MUL_LD;
                    cmd.opa = pmc_pkg::DP_W'(r_wet);
                    cmd.opb = pmc_pkg::MP_W'(r_count);
                    n_cnt   = pmc_pkg::CNT_W'(23);
                    n_state = pmc_pkg::ST_M_CNT;
                end
            end
            pmc_pkg::ST_M_CNT: begin
                cmd.op = pmc_pkg::DP_MUL;
                if (cnt_end) n_state = pmc_pkg::ST_M_DEN_LD;
            end
            pmc_pkg::ST_M_DEN_LD: begin
                cmd.op  = pmc_pkg::DP_MUL_LD;
                cmd.opa = acc;
                cmd.opb = pmc_pkg::MP_W'(r_density);
                n_cnt   = pmc_pkg::CNT_W'(14);
                n_state = pmc_pkg::ST_M_DEN;
            end
            pmc_pkg::ST_M_DEN: begin
                cmd.op = pmc_pkg::DP_MUL;
                if (cnt_end) n_state = pmc_pkg::ST_M_K_LD;
            end
            pmc_pkg::ST_M_K_LD: begin
                cmd.op  = pmc_pkg::DP_MUL_LD;
                cmd.opa = acc;
                cmd.opb = pmc_pkg::MASS_SCALE;
                n_cnt   = pmc_pkg::CNT_W'(29);
                n_state = pmc_pkg::ST_M_K;
            end
            pmc_pkg::ST_M_K: begin
                cmd.op = pmc_pkg::DP_MUL;
                if (cnt_end) n_state = pmc_pkg::ST_M_DL;
            end
            pmc_pkg::ST_M_DL: begin
                // the scale shift is dropped before dividing by volume
                cmd.op  = pmc_pkg::DP_DIV_LD;
                cmd.opa = {acc[111:57], 57'b0};
                cmd.opb = pmc_pkg::MP_W'(r_vol);
                n_cnt   = pmc_pkg::CNT_W'(54);
                n_state = pmc_pkg::ST_M_DIV;
            end
            pmc_pkg::ST_M_DIV: begin
                cmd.op = pmc_pkg::DP_DIV;
                if (cnt_end) n_state = pmc_pkg::ST_ACC;
            end
            pmc_pkg::ST_ACC: begin
                n_pm10 = sat_add(r_pm10, mass);
                if (r_wet <= pmc_pkg::CUT_PM2P5) n_pm25 = sat_add(r_pm25, mass);
                if (r_wet <= pmc_pkg::CUT_PM1)   n_pm1  = sat_add(r_pm1, mass);
                n_state = pmc_pkg::ST_DONE;
            end
            pmc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out.num_per_litre        = r_num;
                    n_out.pm1_mass             = r_last ? r_pm1 : '0;
                    n_out.pm2p5_mass           = r_last ? r_pm25 : '0;
                    n_out.pm10_mass            = r_last ? r_pm10 : '0;
                    n_out.frame_done           = r_last;
                    n_out.volume_too_small     = vol_small;
                    if (r_last) begin
                        n_pm1      = '0;
                        n_pm25     = '0;
                        n_pm10     = '0;
                        n_in_frame = 1'b0;
                    end
                    n_state = pmc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmc_pkg::ST_IDLE;
            r_in_frame  <= 1'b0;
            r_vol       <= '0;
            r_hum       <= '0;
            r_pm1       <= '0;
            r_pm25      <= '0;
            r_pm10      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_frame  <= n_in_frame;
            r_vol       <= n_vol;
            r_hum       <= n_hum;
            r_pm1       <= n_pm1;
            r_pm25      <= n_pm25;
            r_pm10      <= n_pm10;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_count <= n_count;
        r_s     <= n_s;
        r_last  <= n_last;
        r_num   <= n_num;
        r_wet   <= n_wet;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_density <= pmc_pkg::DENSITY_RST;
            r_kappa   <= pmc_pkg::KAPPA_RST;
            r_growth  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pmc_pkg::REG_DENSITY: r_density <= i_cfg_data;
                pmc_pkg::REG_KAPPA:   r_kappa   <= i_cfg_data[11:0];
                pmc_pkg::REG_GROWTH:  r_growth  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_small_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.volume_too_small |-> o_data.num_per_litre == '0
            && o_data.pm1_mass == '0 && o_data.pm10_mass == '0)
        else $error("small volume beat carries nonzero values");

    a_sums_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.frame_done |-> o_data.pm1_mass == '0
            && o_data.pm2p5_mass == '0 && o_data.pm10_mass == '0)
        else $error("mass sums shown before end of frame");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall && !$stable(r_state))
        else $error("accepted bin did not start work");

    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pmc_pkg::ST_DONE && out_free |=> r_out_valid && r_state == pmc_pkg::ST_IDLE)
        else $error("finished result not loaded");

    a_frame_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pmc_pkg::ST_DONE && out_free && r_last |=> !r_in_frame && r_pm10 == '0)
        else $error("frame state not cleared after last bin");
`endif

endmodule

`default_nettype wire

// ===== sv/pmc_serial.sv =====
`default_nettype none

// bit-serial shift-add multiplier and restoring divider sharing one register
module pmc_serial (
    input  wire logic               i_clk,
    input  wire pmc_pkg::t_dp_cmd   i_cmd,
    output logic [pmc_pkg::DP_W-1:0] o_acc
);

    logic [pmc_pkg::DP_W-1:0]  r_acc;
    logic [pmc_pkg::DP_W-1:0]  r_mc;
    logic [pmc_pkg::MP_W-1:0]  r_mp;
    logic [pmc_pkg::DVS_W-1:0] r_rem;
    logic [pmc_pkg::DVS_W-1:0] r_dvs;

    logic [pmc_pkg::DVS_W:0]   trial;
    logic                      ge;

    always_comb begin
        trial = {r_rem, r_acc[pmc_pkg::DP_W-1]};
        ge    = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pmc_pkg::DP_MUL_LD: begin
                r_acc <= '0;
                r_mc  <= i_cmd.opa;
                r_mp  <= i_cmd.opb;
            end
            pmc_pkg::DP_MUL: begin
                if (r_mp[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc <= {r_mc[pmc_pkg::DP_W-2:0], 1'b0};
                r_mp <= {1'b0, r_mp[pmc_pkg::MP_W-1:1]};
            end
            pmc_pkg::DP_DIV_LD: begin
                r_acc <= i_cmd.opa;
                r_rem <= '0;
                r_dvs <= i_cmd.opb[pmc_pkg::DVS_W-1:0];
            end
            pmc_pkg::DP_DIV: begin
                // quotient bits enter at the bottom as dividend bits leave the top
                r_rem <= ge ? pmc_pkg::DVS_W'(trial - {1'b0, r_dvs})
                            : trial[pmc_pkg::DVS_W-1:0];
                r_acc <= {r_acc[pmc_pkg::DP_W-2:0], ge};
            end
            default: begin
            end
        endcase
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire
